// ===== hw/rtl/bms_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bms_pkg
// shared types and constants of the boot mode selector
// ----------------------------------------------------------------------------
package bms_pkg;

  localparam int unsigned CntW   = 24;
  localparam int unsigned HoldW  = 16;
  localparam int unsigned TickW  = 16;
  localparam int unsigned WordW  = 32;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned InDataW  = 88;
  localparam int unsigned OutDataW = 8;

  localparam logic [WordW-1:0] StackMask  = 32'h2FFE_0000;
  localparam logic [WordW-1:0] StackValue = 32'h2002_0000;

  typedef enum logic [1:0] {
    PhInitial = 2'd0,
    PhUpload  = 2'd1,
    PhBoot    = 2'd2,
    PhDone    = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    ActNone      = 3'd0,
    ActUpload    = 3'd1,
    ActJump      = 3'd2,
    ActEraseJump = 3'd3,
    ActHalt      = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    ErrNone = 2'd0,
    ErrMain = 2'd1,
    ErrSide = 2'd2,
    ErrBad  = 2'd3
  } upload_err_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegInitWait    = 3'd0,
    RegWaitBlink   = 3'd1,
    RegUploadBlink = 3'd2,
    RegBootBlink   = 3'd3,
    RegUploadDelay = 3'd4,
    RegBootDelay   = 3'd5,
    RegPressMin    = 3'd6,
    RegHoldMin     = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [WordW-1:0] side_stack_word;
    logic [WordW-1:0] main_stack_word;
    logic             upload_failed;
    logic             button_pressed;
    logic [TickW-1:0] elapsed_ticks;
  } in_item_t;

  typedef struct packed {
    logic    erase_main;
    logic    target_main;
    action_e action;
    phase_e  phase;
    logic    led_toggle;
  } out_item_t;

  function automatic logic image_valid(input logic [WordW-1:0] word);
    return (word & StackMask) == StackValue;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/boot_mode_selector_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// boot_mode_selector_unit
// bootloader mode selector: press classification, upload fallback, boot check
// ----------------------------------------------------------------------------
// One tick report is taken per transfer and gives exactly one result. The
// unit takes a new report in every cycle while no stalled output holds it; a
// report passes an input register and then one stage of compare-and-update
// logic that writes the phase, counters and result register together. The
// ready path runs from m_axis_tready through both stages, so a stalled
// output only holds the unit once both registers are full. Configuration
// writes are always accepted and take effect on the next report processed;
// they are meant to be made while the unit is idle.
// ----------------------------------------------------------------------------
module boot_mode_selector_unit import bms_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // tick reports
  input  wire logic                s_axis_tvalid,
  output      logic                s_axis_tready,
  // elapsed_ticks[15:0], button_pressed[16], upload_failed[17],
  // main_stack_word[49:18], side_stack_word[81:50], zero fill [87:82]
  input  wire logic [InDataW-1:0]  s_axis_tdata,
  // results
  output      logic                m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // led_toggle[0], phase[2:1], action[5:3], target_main[6], erase_main[7]
  output      logic [OutDataW-1:0] m_axis_tdata,
  // configuration writes
  input  wire logic                cfg_valid_i,
  output      logic                cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CntW-1:0]     cfg_data_i
);

  // configuration registers
  logic [CntW-1:0]  init_wait_q, wait_blink_q, upload_blink_q, boot_blink_q;
  logic [CntW-1:0]  upload_delay_q, boot_delay_q;
  logic [HoldW-1:0] press_min_q, hold_min_q;

  // pipeline registers
  logic      in_valid_q;
  in_item_t  in_q;
  logic      out_valid_q;
  out_item_t out_q, out_d;

  // selector state
  logic [CntW-1:0]  blink_count_q, blink_count_d;
  logic [CntW-1:0]  wait_count_q, wait_count_d;
  logic [HoldW-1:0] hold_time_q, hold_time_d;
  phase_e           phase_q, phase_d;
  logic             chosen_q, chosen_d;
  upload_err_e      err_q, err_d;

  logic out_adv, in_adv, in_take;

  // handshakes: result stage moves when empty or drained
  assign out_adv       = !out_valid_q || m_axis_tready;
  assign in_adv        = in_valid_q && out_adv;
  assign s_axis_tready = !in_valid_q || out_adv;
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  // configuration register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_wait_q    <= 24'd3000;
      wait_blink_q   <= 24'd500;
      upload_blink_q <= 24'd100;
      boot_blink_q   <= 24'd1000;
      upload_delay_q <= 24'd100;
      boot_delay_q   <= 24'd1000;
      press_min_q    <= 16'd50;
      hold_min_q     <= 16'd2000;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        RegInitWait:    init_wait_q    <= cfg_data_i;
        RegWaitBlink:   wait_blink_q   <= cfg_data_i;
        RegUploadBlink: upload_blink_q <= cfg_data_i;
        RegBootBlink:   boot_blink_q   <= cfg_data_i;
        RegUploadDelay: upload_delay_q <= cfg_data_i;
        RegBootDelay:   boot_delay_q   <= cfg_data_i;
        RegPressMin:    press_min_q    <= cfg_data_i[HoldW-1:0];
        RegHoldMin:     hold_min_q     <= cfg_data_i[HoldW-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_item_t'(s_axis_tdata[$bits(in_item_t)-1:0]);
    end
  end

  // update logic for one report
  logic [CntW:0]    blink_sum, wait_sum;
  logic [HoldW:0]   hold_sum;
  logic [CntW-1:0]  blink_sat, wait_sat;
  logic [HoldW-1:0] hold_sat;
  logic [CntW-1:0]  blink_lim;
  logic             main_ok, side_ok, pick_ok;

  always_comb begin
    // saturating accumulators
    blink_sum = {1'b0, blink_count_q} + {{(CntW+1-TickW){1'b0}}, in_q.elapsed_ticks};
    wait_sum  = {1'b0, wait_count_q} + {{(CntW+1-TickW){1'b0}}, in_q.elapsed_ticks};
    hold_sum  = {1'b0, hold_time_q} + {1'b0, in_q.elapsed_ticks};
    blink_sat = blink_sum[CntW] ? {CntW{1'b1}} : blink_sum[CntW-1:0];
    wait_sat  = wait_sum[CntW] ? {CntW{1'b1}} : wait_sum[CntW-1:0];
    hold_sat  = hold_sum[HoldW] ? {HoldW{1'b1}} : hold_sum[HoldW-1:0];

    main_ok = image_valid(in_q.main_stack_word);
    side_ok = image_valid(in_q.side_stack_word);
    pick_ok = in_q.button_pressed ? side_ok : main_ok;

    // blink interval of the current phase
    case (phase_q)
      PhInitial: blink_lim = wait_blink_q;
      PhUpload:  blink_lim = upload_blink_q;
      PhBoot:    blink_lim = boot_blink_q;
      default:   blink_lim = {CntW{1'b1}};
    endcase

    blink_count_d = blink_sat;
    wait_count_d  = wait_sat;
    hold_time_d   = hold_time_q;
    phase_d       = phase_q;
    chosen_d      = chosen_q;
    err_d         = err_q;
    out_d.led_toggle  = 1'b0;
    out_d.action      = ActNone;
    out_d.target_main = 1'b0;
    out_d.erase_main  = 1'b0;

    // finished phase never toggles: the limit there is all ones
    if (phase_q != PhDone && blink_sat > blink_lim) begin
      out_d.led_toggle = 1'b1;
      blink_count_d    = '0;
    end

    unique case (phase_q)
      PhInitial: begin
        // timeout first, then a released press may still pick upload
        if (wait_sat > init_wait_q) begin
          wait_count_d = '0;
          phase_d      = PhBoot;
        end
        if (in_q.button_pressed) begin
          hold_time_d = hold_sat;
        end else begin
          if (hold_time_q >= hold_min_q) begin
            wait_count_d = '0;
            phase_d      = PhUpload;
            chosen_d     = 1'b0;
          end else if (hold_time_q >= press_min_q) begin
            wait_count_d = '0;
            phase_d      = PhUpload;
            chosen_d     = 1'b1;
          end
          hold_time_d = '0;
        end
      end
      PhUpload: begin
        if (wait_sat >= upload_delay_q) begin
          out_d.action      = ActUpload;
          out_d.target_main = chosen_q;
          if (in_q.upload_failed) begin
            err_d = chosen_q ? ErrMain : ErrSide;
          end
          wait_count_d = '0;
          phase_d      = PhBoot;
        end
      end
      PhBoot: begin
        if (wait_sat >= boot_delay_q) begin
          chosen_d     = !in_q.button_pressed;
          out_d.action = ActHalt;
          // fall back to the image that did not fail and erase the other
          case (err_q)
            ErrNone: begin
              if (pick_ok) begin
                out_d.action      = ActJump;
                out_d.target_main = !in_q.button_pressed;
              end
            end
            ErrMain: begin
              if (side_ok) begin
                out_d.action     = ActEraseJump;
                out_d.erase_main = 1'b1;
              end
            end
            ErrSide: begin
              if (main_ok) begin
                out_d.action      = ActEraseJump;
                out_d.target_main = 1'b1;
              end
            end
            default: ;
          endcase
          phase_d = PhDone;
        end
      end
      PhDone: ;
      default: ;
    endcase

    out_d.phase = phase_d;
  end

  // state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blink_count_q <= '0;
      wait_count_q  <= '0;
      hold_time_q   <= '0;
      phase_q       <= PhInitial;
      chosen_q      <= 1'b1;
      err_q         <= ErrNone;
      out_valid_q   <= 1'b0;
    end else begin
      if (out_adv) begin
        out_valid_q <= in_valid_q;
      end
      if (in_adv) begin
        blink_count_q <= blink_count_d;
        wait_count_q  <= wait_count_d;
        hold_time_q   <= hold_time_d;
        phase_q       <= phase_d;
        chosen_q      <= chosen_d;
        err_q         <= err_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_adv) begin
      out_q <= out_d;
    end
  end

endmodule
`default_nettype wire
